>>> hdl/midpoint_ellipse_rasterizer_top_macros.svh
// Assertion macros for the ellipse rasterizer RTL
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define MER_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mer assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent
`define MER_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mer assertion failed: next-cycle check");

`else

`define MER_ASSERT_NOW(lbl, clk, rst, ante, cons)

`define MER_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/mer_pkg.sv
package mer_pkg;

   localparam int OUT_W    = 12;
   localparam int COLOUR_W = 8;

   // Request function codes
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_GY,
      ST_D_INIT,
      ST_XX1,
      ST_YM2,
      ST_A1,
      ST_A2,
      ST_A3,
      ST_A4,
      ST_SEED,
      ST_STEP_A,
      ST_STEP_B,
      ST_EMIT
   } mer_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_RX,
      OP_SQ_RY,
      OP_GY,
      OP_D_INIT,
      OP_XX1,
      OP_YM2,
      OP_A1,
      OP_A2,
      OP_A3,
      OP_A4,
      OP_SEED,
      OP_STEP_A,
      OP_STEP_B,
      OP_EMIT
   } mer_op_type;

   typedef struct packed {
      mer_op_type op;
   } mer_cmd_type;

   typedef struct packed {
      logic busy;
      logic region_two;
      logic grad_lt;
      logic y_zero;
      logic out_full;
   } mer_status_type;

endpackage

>>> hdl/mer_req_if.sv
interface mer_req_if import mer_pkg::*; #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 9
);
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [COORD_BITS-1:0]  centre_x;
   logic [COORD_BITS-1:0]  centre_y;
   logic [RADIUS_BITS-1:0] radius_x;
   logic [RADIUS_BITS-1:0] radius_y;
   logic [COLOUR_W-1:0]    pixel_colour;

   modport source (
      output valid, func, centre_x, centre_y, radius_x, radius_y, pixel_colour,
      input  ready
   );

   modport sink (
      input  valid, func, centre_x, centre_y, radius_x, radius_y, pixel_colour,
      output ready
   );
endinterface

>>> hdl/mer_rsp_if.sv
interface mer_rsp_if import mer_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  px_right;
   logic signed [OUT_W-1:0]  px_left;
   logic signed [OUT_W-1:0]  py_lower;
   logic signed [OUT_W-1:0]  py_upper;
   logic [COLOUR_W-1:0]      colour_out;
   logic                     last_point;

   modport source (
      output valid, px_right, px_left, py_lower, py_upper, colour_out, last_point,
      input  ready
   );

   modport sink (
      input  valid, px_right, px_left, py_lower, py_upper, colour_out, last_point,
      output ready
   );
endinterface

>>> hdl/mer_ctrl.sv
module mer_ctrl import mer_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_func,
   output logic           req_ready,
   input  logic           rsp_ready,
   input  mer_status_type status,
   output mer_cmd_type    cmd
);

   mer_state_type state_ff;
   mer_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence the datapath one operation per cycle, but hold in emit while a result waits untaken
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_START) begin
                  cmd.op   = OP_LOAD;
                  state_in = ST_SQ_RX;
               end else if (status.busy) begin
                  // leave region one once the gradients cross
                  if (status.region_two || status.grad_lt) begin
                     state_in = ST_STEP_A;
                  end else begin
                     state_in = ST_XX1;
                  end
               end
            end
         end
         ST_SQ_RX: begin
            cmd.op   = OP_SQ_RX;
            state_in = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            cmd.op   = OP_SQ_RY;
            state_in = ST_GY;
         end
         ST_GY: begin
            cmd.op   = OP_GY;
            state_in = ST_D_INIT;
         end
         ST_D_INIT: begin
            cmd.op   = OP_D_INIT;
            state_in = ST_EMIT;
         end
         ST_XX1: begin
            cmd.op   = OP_XX1;
            state_in = ST_YM2;
         end
         ST_YM2: begin
            cmd.op   = OP_YM2;
            state_in = ST_A1;
         end
         ST_A1: begin
            cmd.op   = OP_A1;
            state_in = ST_A2;
         end
         ST_A2: begin
            cmd.op   = OP_A2;
            state_in = ST_A3;
         end
         ST_A3: begin
            cmd.op   = OP_A3;
            state_in = ST_A4;
         end
         ST_A4: begin
            cmd.op   = OP_A4;
            state_in = ST_SEED;
         end
         ST_SEED: begin
            cmd.op   = OP_SEED;
            state_in = ST_STEP_A;
         end
         ST_STEP_A: begin
            cmd.op   = OP_STEP_A;
            state_in = ST_STEP_B;
         end
         ST_STEP_B: begin
            cmd.op   = OP_STEP_B;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (!status.out_full || rsp_ready) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/mer_dp.sv
module mer_dp import mer_pkg::*; #(
   parameter int RADIUS_BITS = 9,
   parameter int COORD_BITS  = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mer_cmd_type             cmd,
   input  logic [COORD_BITS-1:0]   req_centre_x,
   input  logic [COORD_BITS-1:0]   req_centre_y,
   input  logic [RADIUS_BITS-1:0]  req_radius_x,
   input  logic [RADIUS_BITS-1:0]  req_radius_y,
   input  logic [COLOUR_W-1:0]     req_pixel_colour,
   input  logic                    rsp_ready,
   output mer_status_type          status,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] px_right,
   output logic signed [OUT_W-1:0] px_left,
   output logic signed [OUT_W-1:0] py_lower,
   output logic signed [OUT_W-1:0] py_upper,
   output logic [COLOUR_W-1:0]     colour_out,
   output logic                    last_point
);

   localparam int R    = RADIUS_BITS;
   localparam int XW   = R + 1;
   localparam int SQW  = 2 * R;
   localparam int TAW  = 2 * R + 3;
   localparam int MAW  = SQW;
   localparam int MBW  = TAW;
   localparam int PW   = MAW + MBW;
   localparam int GW   = 3 * R + 4;
   localparam int DW   = 4 * R + 7;
   localparam int MW0  = (COORD_BITS > XW) ? COORD_BITS : XW;
   localparam int SW   = (MW0 > OUT_W) ? MW0 : OUT_W;

   // Held request fields
   logic [COORD_BITS-1:0] centre_x_ff;
   logic [COORD_BITS-1:0] centre_y_ff;
   logic [COLOUR_W-1:0]   colour_ff;
   logic [R-1:0]          rx_ff;
   logic [R-1:0]          ry_ff;

   // Walk state
   logic [XW-1:0]         off_x_ff;
   logic [R-1:0]          off_y_ff;
   logic [SQW-1:0]        rx_sq_ff;
   logic [SQW-1:0]        ry_sq_ff;
   logic signed [GW-1:0]  grad_x_ff;
   logic signed [GW-1:0]  grad_y_ff;
   logic signed [DW-1:0]  decision_ff;
   logic                  branch_ff;
   logic                  busy_ff;
   logic                  region_two_ff;
   logic                  out_valid_ff;

   // Seed temporaries
   logic [TAW-1:0]        ta_ff;
   logic [SQW-1:0]        tb_ff;
   logic [PW-1:0]         prod_ff;
   logic signed [DW-1:0]  acc_ff;

   // Shared multiplier
   logic [MAW-1:0]        mul_a;
   logic [MBW-1:0]        mul_b;
   logic [PW-1:0]         mul_p;
   logic [R-1:0]          y_minus;

   // Arithmetic views
   logic signed [DW-1:0]  rx_sq_d;
   logic signed [DW-1:0]  ry_sq_d;
   logic signed [DW-1:0]  prod_d;
   logic signed [DW-1:0]  gx_d;
   logic signed [DW-1:0]  gy_d;
   logic signed [DW-1:0]  d_init;
   logic signed [DW-1:0]  d_step;
   logic signed [DW-1:0]  acc_round;
   logic signed [GW-1:0]  two_rx_sq;
   logic signed [GW-1:0]  two_ry_sq;
   logic                  use_gx;
   logic                  use_gy;
   logic                  step_branch;
   logic [SW-1:0]         sum_xr;
   logic [SW-1:0]         sum_xl;
   logic [SW-1:0]         sum_yl;
   logic [SW-1:0]         sum_yu;

   // Select multiplier operands
   always_comb begin
      y_minus = off_y_ff - R'(1);
      mul_a   = '0;
      mul_b   = '0;
      case (cmd.op)
         OP_SQ_RX: begin
            mul_a = MAW'(rx_ff);
            mul_b = MBW'(rx_ff);
         end
         OP_SQ_RY: begin
            mul_a = MAW'(ry_ff);
            mul_b = MBW'(ry_ff);
         end
         OP_GY: begin
            mul_a = rx_sq_ff;
            mul_b = MBW'(ry_ff);
         end
         OP_XX1: begin
            mul_a = MAW'(off_x_ff);
            mul_b = MBW'(off_x_ff) + MBW'(1);
         end
         OP_YM2: begin
            mul_a = MAW'(y_minus);
            mul_b = MBW'(y_minus);
         end
         OP_A1: begin
            mul_a = ry_sq_ff;
            mul_b = ta_ff;
         end
         OP_A2: begin
            mul_a = rx_sq_ff;
            mul_b = MBW'(tb_ff);
         end
         OP_A3: begin
            mul_a = rx_sq_ff;
            mul_b = MBW'(ry_sq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   // Decision and gradient arithmetic
   always_comb begin
      rx_sq_d   = DW'(rx_sq_ff);
      ry_sq_d   = DW'(ry_sq_ff);
      prod_d    = DW'(prod_ff);
      gx_d      = DW'(grad_x_ff);
      gy_d      = DW'(grad_y_ff);
      two_rx_sq = GW'({rx_sq_ff, 1'b0});
      two_ry_sq = GW'({ry_sq_ff, 1'b0});
      // quarter terms round half up: floor((n + 2) / 4)
      d_init    = ((ry_sq_d <<< 2) - (prod_d <<< 2) + rx_sq_d + DW'(2)) >>> 2;
      acc_round = (acc_ff + DW'(2)) >>> 2;
      // region one steps y on a non-negative decision, region two steps x on a
      // non-positive one
      if (region_two_ff) begin
         step_branch = (decision_ff == '0) || decision_ff[DW-1];
      end else begin
         step_branch = !decision_ff[DW-1];
      end
      use_gx = !region_two_ff || branch_ff;
      use_gy = region_two_ff || branch_ff;
      d_step = decision_ff + (region_two_ff ? rx_sq_d : ry_sq_d)
             + (use_gx ? gx_d : '0) - (use_gy ? gy_d : '0);
   end

   // Mirrored pixel coordinates, wrapped to the output width
   always_comb begin
      sum_xr = SW'(centre_x_ff) + SW'(off_x_ff);
      sum_xl = SW'(centre_x_ff) - SW'(off_x_ff);
      sum_yl = SW'(centre_y_ff) + SW'(off_y_ff);
      sum_yu = SW'(centre_y_ff) - SW'(off_y_ff);
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            centre_x_ff <= req_centre_x;
            centre_y_ff <= req_centre_y;
            colour_ff   <= req_pixel_colour;
            rx_ff       <= req_radius_x;
            ry_ff       <= req_radius_y;
            off_x_ff    <= '0;
            off_y_ff    <= req_radius_y;
            grad_x_ff   <= '0;
         end
         OP_SQ_RX: begin
            rx_sq_ff <= mul_p[SQW-1:0];
         end
         OP_SQ_RY: begin
            ry_sq_ff <= mul_p[SQW-1:0];
         end
         OP_GY: begin
            prod_ff <= mul_p;
         end
         OP_D_INIT: begin
            grad_y_ff   <= GW'({prod_ff, 1'b0});
            decision_ff <= d_init;
         end
         OP_XX1: begin
            ta_ff <= mul_p[TAW-1:0];
         end
         OP_YM2: begin
            tb_ff <= mul_p[SQW-1:0];
         end
         OP_A1: begin
            prod_ff <= mul_p;
         end
         OP_A2: begin
            acc_ff  <= (prod_d <<< 2) + ry_sq_d;
            prod_ff <= mul_p;
         end
         OP_A3: begin
            acc_ff  <= acc_ff + (prod_d <<< 2);
            prod_ff <= mul_p;
         end
         OP_A4: begin
            acc_ff <= acc_ff - (prod_d <<< 2);
         end
         OP_SEED: begin
            decision_ff <= acc_round;
         end
         OP_STEP_A: begin
            branch_ff <= step_branch;
            if (!region_two_ff || step_branch) begin
               off_x_ff  <= off_x_ff + XW'(1);
               grad_x_ff <= grad_x_ff + two_ry_sq;
            end
            if (region_two_ff || step_branch) begin
               off_y_ff  <= off_y_ff - R'(1);
               grad_y_ff <= grad_y_ff - two_rx_sq;
            end
         end
         OP_STEP_B: begin
            decision_ff <= d_step;
         end
         OP_EMIT: begin
            px_right   <= sum_xr[OUT_W-1:0];
            px_left    <= sum_xl[OUT_W-1:0];
            py_lower   <= sum_yl[OUT_W-1:0];
            py_upper   <= sum_yu[OUT_W-1:0];
            colour_out <= colour_ff;
            last_point <= (off_y_ff == '0);
         end
         default: begin
         end
      endcase
   end

   // Control flags and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         region_two_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               busy_ff       <= 1'b1;
               region_two_ff <= 1'b0;
            end
            OP_SEED: begin
               region_two_ff <= 1'b1;
            end
            OP_EMIT: begin
               busy_ff <= (off_y_ff != '0);
            end
            default: begin
            end
         endcase
         if (cmd.op == OP_EMIT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign status.busy       = busy_ff;
   assign status.region_two = region_two_ff;
   assign status.grad_lt    = (grad_x_ff < grad_y_ff);
   assign status.y_zero     = (off_y_ff == '0);
   assign status.out_full   = out_valid_ff;

endmodule

>>> hdl/midpoint_ellipse_rasterizer_top.sv
// Channel   Direction  Handshake      Payload
// req_if    in         valid/ready    func, centre_x, centre_y, radius_x, radius_y,
//                                     pixel_colour
// rsp_if    out        valid/ready    px_right, px_left, py_lower, py_upper,
//                                     colour_out, last_point
//
// Start request: after the accept, three squaring or product passes of the shared
// multiplier, then the initial decision, then the result write.
// Advance request: step, decision update, result write; the first advance into region
// two first runs the seed products through the same multiplier and sets the new seed.
// Reset is synchronous and clears the controller, the busy and region flags
// and the output valid. A request is taken while a result still waits; a stalled
// result only holds back the next result write.
`include "midpoint_ellipse_rasterizer_top_macros.svh"

module midpoint_ellipse_rasterizer_top import mer_pkg::*; #(
   parameter int RADIUS_BITS = 9,
   parameter int COORD_BITS  = 10
) (
   input logic         clock,
   input logic         reset,
   mer_req_if.sink     req_if,
   mer_rsp_if.source   rsp_if
);

   mer_cmd_type    cmd;
   mer_status_type status;
   logic           ctl_ready;

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_ready (ctl_ready),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mer_dp #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_centre_x     (req_if.centre_x),
      .req_centre_y     (req_if.centre_y),
      .req_radius_x     (req_if.radius_x),
      .req_radius_y     (req_if.radius_y),
      .req_pixel_colour (req_if.pixel_colour),
      .rsp_ready        (rsp_if.ready),
      .status           (status),
      .rsp_valid        (rsp_if.valid),
      .px_right         (rsp_if.px_right),
      .px_left          (rsp_if.px_left),
      .py_lower         (rsp_if.py_lower),
      .py_upper         (rsp_if.py_upper),
      .colour_out       (rsp_if.colour_out),
      .last_point       (rsp_if.last_point)
   );

   assign req_if.ready = ctl_ready;

   // Busy drops exactly with the point that ends the ellipse
   `MER_ASSERT_NEXT(a_emit_busy, clock, reset, cmd.op == OP_EMIT, status.busy == !rsp_if.last_point)
   // Never overwrite a result that has not been taken
   `MER_ASSERT_NOW(a_emit_slot, clock, reset, cmd.op == OP_EMIT, !rsp_if.valid || rsp_if.ready)
   // A step only runs on a live ellipse with rows left
   `MER_ASSERT_NOW(a_step_live, clock, reset, cmd.op == OP_STEP_A, status.busy && !status.y_zero)

endmodule

>>> test/mer_point_checker.sv
module mer_point_checker import mer_pkg::*; (
   input  logic clock,
   input  logic reset,
   mer_req_if   req_if,
   mer_rsp_if   rsp_if,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W  = 10;
   localparam int RADIUS_W = 9;

   typedef struct packed {
      logic [OUT_W-1:0]    px_right;
      logic [OUT_W-1:0]    px_left;
      logic [OUT_W-1:0]    py_lower;
      logic [OUT_W-1:0]    py_upper;
      logic [COLOUR_W-1:0] colour;
      logic                last;
   } ellipse_point_type;

   ellipse_point_type expected_points[$];
   int                mismatch_count = 0;

   // Ellipse being traced: offsets, decision and gradient terms, latched start data
   logic                tracing       = 1'b0;
   logic                in_region_two = 1'b0;
   int                  x_off         = 0;
   int                  y_off         = 0;
   longint              decision_v    = 0;
   longint              grad_x_v      = 0;
   longint              grad_y_v      = 0;
   longint              a_sq          = 0;
   longint              b_sq          = 0;
   logic [COORD_W-1:0]  centre_col    = '0;
   logic [COORD_W-1:0]  centre_row    = '0;
   logic [COLOUR_W-1:0] ink           = '0;

   // Divide by four, rounding half up (arithmetic shift floors)
   function automatic longint quarter_up(input longint n);
      return (n + 2) >>> 2;
   endfunction

   // Mirror the current offsets around the centre; the point on the x axis ends the ellipse
   function automatic ellipse_point_type plot_point();
      ellipse_point_type p;
      p.px_right = OUT_W'(centre_col) + x_off[OUT_W-1:0];
      p.px_left  = OUT_W'(centre_col) - x_off[OUT_W-1:0];
      p.py_lower = OUT_W'(centre_row) + y_off[OUT_W-1:0];
      p.py_upper = OUT_W'(centre_row) - y_off[OUT_W-1:0];
      p.colour   = ink;
      p.last     = (y_off == 0);
      if (p.last) begin
         tracing = 1'b0;
      end
      return p;
   endfunction

   // Advance the traced ellipse by one request; returns 1 when a point comes out
   function automatic logic next_ellipse_point(
      input  logic                func,
      input  logic [COORD_W-1:0]  cx,
      input  logic [COORD_W-1:0]  cy,
      input  logic [RADIUS_W-1:0] rx,
      input  logic [RADIUS_W-1:0] ry,
      input  logic [COLOUR_W-1:0] colour,
      output ellipse_point_type   p
   );
      longint a;
      longint b;
      longint ym;
      a = longint'(rx);
      b = longint'(ry);
      p = '0;

      // start: latch, seed region one, emit the top point
      if (func == FUNC_START) begin
         centre_col    = cx;
         centre_row    = cy;
         ink           = colour;
         a_sq          = a * a;
         b_sq          = b * b;
         x_off         = 0;
         y_off         = int'(b);
         grad_x_v      = 0;
         grad_y_v      = 2 * a_sq * b;
         decision_v    = quarter_up(4 * b_sq - 4 * a_sq * b + a_sq);
         in_region_two = 1'b0;
         tracing       = 1'b1;
         p = plot_point();
         return 1'b1;
      end

      // advance with no ellipse in progress: drop
      if (!tracing) begin
         return 1'b0;
      end

      // region one: step x, maybe y
      if (!in_region_two && grad_x_v < grad_y_v) begin
         x_off++;
         grad_x_v += 2 * b_sq;
         if (decision_v < 0) begin
            decision_v += b_sq + grad_x_v;
         end else begin
            y_off--;
            grad_y_v -= 2 * a_sq;
            decision_v += b_sq + grad_x_v - grad_y_v;
         end
         p = plot_point();
         return 1'b1;
      end

      // entering region two: reseed the decision exactly
      if (!in_region_two) begin
         ym = longint'(y_off) - 1;
         decision_v = quarter_up(4 * b_sq * (longint'(x_off) * x_off + x_off) + b_sq
                                 + 4 * a_sq * ym * ym - 4 * a_sq * b_sq);
         in_region_two = 1'b1;
      end

      // region two: step y, maybe x
      y_off--;
      grad_y_v -= 2 * a_sq;
      if (decision_v > 0) begin
         decision_v += a_sq - grad_y_v;
      end else begin
         x_off++;
         grad_x_v += 2 * b_sq;
         decision_v += a_sq - grad_y_v + grad_x_v;
      end
      p = plot_point();
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                       input logic [OUT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      ellipse_point_type seen;
      ellipse_point_type want;
      ellipse_point_type fresh;
      logic              yields;
      if (reset) begin
         tracing       = 1'b0;
         in_region_two = 1'b0;
         x_off         = 0;
         y_off         = 0;
         decision_v    = 0;
         grad_x_v      = 0;
         grad_y_v      = 0;
         a_sq          = 0;
         b_sq          = 0;
         centre_col    = '0;
         centre_row    = '0;
         ink           = '0;
         expected_points.delete();
      end else begin
         // compare each delivered point with the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            seen = {rsp_if.px_right, rsp_if.px_left, rsp_if.py_lower, rsp_if.py_upper,
                    rsp_if.colour_out, rsp_if.last_point};
            if (expected_points.size() == 0) begin
               $display("%0t: point expected none, got %h", $time, seen);
               mismatch_count++;
            end else begin
               want = expected_points.pop_front();
               check_field("px_right", want.px_right, seen.px_right);
               check_field("px_left", want.px_left, seen.px_left);
               check_field("py_lower", want.py_lower, seen.py_lower);
               check_field("py_upper", want.py_upper, seen.py_upper);
               check_field("colour_out", OUT_W'(want.colour), OUT_W'(seen.colour));
               check_field("last_point", OUT_W'(want.last), OUT_W'(seen.last));
            end
         end

         // predict the point each accepted request causes
         if (req_if.valid && req_if.ready) begin
            yields = next_ellipse_point(req_if.func, req_if.centre_x, req_if.centre_y,
                                        req_if.radius_x, req_if.radius_y,
                                        req_if.pixel_colour, fresh);
            if (yields) begin
               expected_points.push_back(fresh);
            end
         end
      end
      failures    <= mismatch_count;
      outstanding <= expected_points.size();
   end

endmodule

>>> test/tb_top.sv
module tb_top import mer_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_GOAL     = 1750;
   // Every ellipse yields at least one point, so this many ellipses means the block is stuck
   localparam int ELLIPSE_LIMIT = 4 * ITEM_GOAL;
   // The longest advance is one entering region two, which runs the seed steps first; sender
   // gaps and receiver stalls are short random runs, so this many quiet cycles means a hang.
   localparam int IDLE_LIMIT    = 2000;
   localparam int TAIL_CYCLES   = 24;

   typedef enum logic [1:0] {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY} drain_mode_type;

   logic           clock = 1'b0;
   logic           reset;
   int             failures;
   int             outstanding;
   int             points_seen = 0;
   int             ends_seen   = 0;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   drain_mode_type drain_mode  = DRAIN_FREE;
   int             drain_left  = 0;

   mer_req_if #(.COORD_BITS(10), .RADIUS_BITS(9)) req_ch ();
   mer_rsp_if rsp_ch ();

   midpoint_ellipse_rasterizer_top #(.RADIUS_BITS(9), .COORD_BITS(10)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   mer_point_checker point_check (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Receiver: switch at random between free, light and heavy stalling, holding each mode for a random span
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 2));
         drain_left <= $urandom_range(32, 256);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_FREE:  rsp_ch.ready <= 1'b1;
         DRAIN_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default:     rsp_ch.ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   // Count delivered points and finished ellipses to pace the stimulus
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         points_seen <= points_seen + 1;
         if (rsp_ch.last_point) begin
            ends_seen <= ends_seen + 1;
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drive one request in bursts with random gaps; return at its accepting edge
   task automatic send_request(input logic func, input logic [9:0] cx, input logic [9:0] cy,
                               input logic [8:0] rx, input logic [8:0] ry,
                               input logic [7:0] colour);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.centre_x     <= cx;
      req_ch.centre_y     <= cy;
      req_ch.radius_x     <= rx;
      req_ch.radius_y     <= ry;
      req_ch.pixel_colour <= colour;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Advance with junk payload; the block ignores it
   task automatic send_advance();
      send_request(FUNC_ADVANCE, 10'($urandom), 10'($urandom), 9'($urandom), 9'($urandom),
                   8'($urandom));
   endtask

   // Start an ellipse, then advance until its last point shows up, or only `cut`
   // times when cut is set (cut below ry keeps the ellipse busy for the next start)
   task automatic draw_ellipse(input logic [9:0] cx, input logic [9:0] cy,
                               input logic [8:0] rx, input logic [8:0] ry,
                               input logic [7:0] colour, input int cut);
      int mark;
      int steps;
      int cap;
      mark  = ends_seen;
      cap   = (cut >= 0) ? cut : int'(rx) + int'(ry) + 16;
      steps = 0;
      send_request(FUNC_START, cx, cy, rx, ry, colour);
      while (steps < cap && (cut >= 0 || ends_seen == mark)) begin
         send_advance();
         steps++;
      end
   endtask

   // Mostly small radii, sometimes medium, rarely anything up to the maximum
   function automatic logic [8:0] pick_radius();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 9'($urandom_range(0, 15));
      end
      if (roll < 97) begin
         return 9'($urandom_range(0, 63));
      end
      return 9'($urandom_range(0, 511));
   endfunction

   initial begin
      logic [8:0] rx;
      logic [8:0] ry;
      int         cut;
      int         seq;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_START;
      req_ch.centre_x     = '0;
      req_ch.centre_y     = '0;
      req_ch.radius_x     = '0;
      req_ch.radius_y     = '0;
      req_ch.pixel_colour = '0;
      reset               = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // advance with nothing in progress
      send_advance();
      // degenerate ellipse: single point, also last
      draw_ellipse(10'd0, 10'd0, 9'd0, 9'd0, 8'h00, -1);
      // zero horizontal radius skips region one; the lower row passes the top of the 10-bit centre range
      draw_ellipse(10'd1023, 10'd1023, 9'd0, 9'd3, 8'hFF, -1);
      // zero vertical radius: first point is the last one
      draw_ellipse(10'd512, 10'd7, 9'd3, 9'd0, 8'h81, -1);
      // restart while an ellipse is still being traced
      draw_ellipse(10'd0, 10'd1023, 9'd5, 9'd4, 8'hAA, 2);
      draw_ellipse(10'd1, 10'd2, 9'd4, 9'd6, 8'h55, -1);
      send_advance();

      // random ellipses, one at the largest size, some cut short
      seq = 0;
      while (points_seen < ITEM_GOAL && seq < ELLIPSE_LIMIT) begin
         if (seq == 5) begin
            rx = 9'd511;
            ry = 9'd511;
         end else begin
            rx = pick_radius();
            ry = pick_radius();
         end
         cut = -1;
         if (ry > 0 && $urandom_range(0, 99) < 20) begin
            cut = $urandom_range(0, int'(ry) - 1);
         end
         draw_ellipse(10'($urandom), 10'($urandom), rx, ry, 8'($urandom), cut);
         if (cut < 0 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) send_advance();
         end
         seq++;
      end

      // drain, let stragglers show, then give the verdict
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0 && points_seen >= ITEM_GOAL) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
